### rtl/sct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sensor confidence tracker
// Holds the item formats, the configuration layout and the fixed codes used
// by the channel interfaces and all modules of the block.
// ---------------------------------------------------------------------------
package sct_pkg;

    // Channel map: 0-2 accelerometer, 3-5 gyroscope, 6 barometer, 7-9 magnetometer.
    localparam int unsigned NUM_CHANNELS = 10;
    localparam int unsigned CH_W         = 4;
    localparam logic [CH_W-1:0] LAST_ACCEL_CH = 4'd2;
    localparam logic [CH_W-1:0] LAST_GYRO_CH  = 4'd5;
    localparam logic [CH_W-1:0] BARO_CHANNEL  = 4'd6;
    localparam logic [CH_W-1:0] LAST_CHANNEL  = 4'd9;
    localparam logic [CH_W-1:0] GPS_SOURCE    = 4'd10;

    // Confidence is Q1.15, so 1.0 is 32768.
    localparam logic [15:0] CONF_ONE  = 16'd32768;
    localparam logic [15:0] CONF_ZERO = 16'd0;

    // Item kinds.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_GPS    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TIMEOUT     = 3'd0,
        CFG_RECOVERY    = 3'd1,
        CFG_PENALTY     = 3'd2,
        CFG_LIMIT_ACCEL = 3'd3,
        CFG_LIMIT_GYRO  = 3'd4,
        CFG_LIMIT_BARO  = 3'd5,
        CFG_LIMIT_MAG   = 3'd6,
        CFG_SEA_LEVEL   = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_TIMEOUT     = 32'd100000;
    localparam logic [15:0] RST_RECOVERY    = 16'd328;
    localparam logic [15:0] RST_PENALTY     = 16'd32768;
    localparam logic [30:0] RST_LIMIT_ACCEL = 31'd81920;
    localparam logic [30:0] RST_LIMIT_GYRO  = 31'd20480;
    localparam logic [30:0] RST_LIMIT_BARO  = 31'd2048000;
    localparam logic [30:0] RST_LIMIT_MAG   = 31'd204800;
    localparam logic [30:0] RST_SEA_LEVEL   = 31'd415027200;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0] timeout_us;
        logic [15:0] recovery_rate;
        logic [15:0] penalty_factor;
        logic [30:0] spike_limit_accel;
        logic [30:0] spike_limit_gyro;
        logic [30:0] spike_limit_baro;
        logic [30:0] spike_limit_mag;
        logic [30:0] sea_level_default;
    } t_cfg;

    // One input word. Samples are signed Q20.12.
    typedef struct packed {
        logic               mode;
        logic [CH_W-1:0]    channel;
        logic signed [31:0] sample_value;
        logic [31:0]        sensor_stamp;
        logic [31:0]        current_time;
        logic               gps_fix;
    } t_in_item;

    // One result word.
    typedef struct packed {
        logic [CH_W-1:0] source;
        logic [15:0]     confidence;
        logic            timed_out;
        logic            spike;
    } t_out_item;

    // Input register contents handed to the update stage.
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

endpackage

### rtl/sct_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_in_if: input word channel
// Valid/ready channel carrying one input word of the tracker.
// ---------------------------------------------------------------------------
interface sct_in_if;
    logic              valid;
    logic              ready;
    sct_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sct_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_out_if: result word channel
// Valid/ready channel carrying one result word of the tracker.
// ---------------------------------------------------------------------------
interface sct_out_if;
    logic               valid;
    logic               ready;
    sct_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sct_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_cfg_regs: configuration register file
// Write-only registers for timeout, recovery, penalty, spike limits and the
// barometer seed, with their reset values.
// ---------------------------------------------------------------------------
module sct_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output sct_pkg::t_cfg                       o_cfg
);
    import sct_pkg::*;

    t_cfg r_cfg;

    // Decode the index and load the addressed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_us        <= RST_TIMEOUT;
            r_cfg.recovery_rate     <= RST_RECOVERY;
            r_cfg.penalty_factor    <= RST_PENALTY;
            r_cfg.spike_limit_accel <= RST_LIMIT_ACCEL;
            r_cfg.spike_limit_gyro  <= RST_LIMIT_GYRO;
            r_cfg.spike_limit_baro  <= RST_LIMIT_BARO;
            r_cfg.spike_limit_mag   <= RST_LIMIT_MAG;
            r_cfg.sea_level_default <= RST_SEA_LEVEL;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT:     r_cfg.timeout_us        <= i_cfg_data;
                CFG_RECOVERY:    r_cfg.recovery_rate     <= i_cfg_data[15:0];
                CFG_PENALTY:     r_cfg.penalty_factor    <= i_cfg_data[15:0];
                CFG_LIMIT_ACCEL: r_cfg.spike_limit_accel <= i_cfg_data[30:0];
                CFG_LIMIT_GYRO:  r_cfg.spike_limit_gyro  <= i_cfg_data[30:0];
                CFG_LIMIT_BARO:  r_cfg.spike_limit_baro  <= i_cfg_data[30:0];
                CFG_LIMIT_MAG:   r_cfg.spike_limit_mag   <= i_cfg_data[30:0];
                CFG_SEA_LEVEL:   r_cfg.sea_level_default <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/sct_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_in_stage: input register
// Captures one input word and holds it until the update stage takes it.
// ---------------------------------------------------------------------------
module sct_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sct_in_if.sink          i_in,
    input  logic            i_advance,
    output sct_pkg::t_stage o_stage
);
    import sct_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // The register is free when empty or when its word moves on this cycle.
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Word register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

### rtl/sct_track.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sct_track: confidence update stage
// Holds the per-channel and GPS state, works out the new confidence for the
// word in the input register and loads the result register.
// ---------------------------------------------------------------------------
module sct_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sct_pkg::t_cfg   i_cfg,
    input  sct_pkg::t_stage i_stage,
    output logic            o_advance,
    sct_out_if.source       o_out
);
    import sct_pkg::*;

    // Channel state.
    logic [31:0]             r_last   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_seeded;
    logic [15:0]             r_conf   [NUM_CHANNELS];
    logic [15:0]             r_gps_conf;

    // Result register.
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    t_in_item                item;
    logic                    is_gps;
    logic                    in_range;
    logic [CH_W-1:0]         ch_idx;
    logic                    produce;

    logic [31:0]             age;
    logic                    age_over;
    logic                    ch_stale;
    logic                    gps_stale;

    logic [31:0]             seed_value;
    logic [31:0]             last_eff;
    logic [15:0]             conf_old;
    logic [30:0]             limit;
    logic signed [32:0]      diff;
    logic [32:0]             jump;
    logic                    is_spike;

    logic [31:0]             pen_prod;
    logic [15:0]             conf_pen;
    logic [16:0]             ch_sum;
    logic [15:0]             ch_rec;
    logic [16:0]             gps_sum;
    logic [15:0]             gps_rec;

    logic [15:0]             n_conf;
    logic [31:0]             n_last;

    assign item     = i_stage.item;
    assign is_gps   = (item.mode == MODE_GPS);
    assign in_range = (item.channel <= LAST_CHANNEL);
    assign ch_idx   = in_range ? item.channel : {CH_W{1'b0}};
    assign produce  = is_gps || in_range;

    // The stage moves when its word is present and the result slot is free.
    assign o_advance = i_stage.valid && (!r_out_valid || o_out.ready);

    // Age checks: the channel test does not wrap, the GPS test does.
    assign age       = item.current_time - item.sensor_stamp;
    assign age_over  = (age > i_cfg.timeout_us);
    assign ch_stale  = (item.current_time > item.sensor_stamp) && age_over;
    assign gps_stale = age_over || !item.gps_fix;

    // First sample seeds the last value; a barometer seed must be positive.
    always_comb begin
        seed_value = item.sample_value;
        if (ch_idx == BARO_CHANNEL && !(item.sample_value > 32'sd0)) begin
            seed_value = {1'b0, i_cfg.sea_level_default};
        end
    end

    assign last_eff = r_seeded[ch_idx] ? r_last[ch_idx] : seed_value;
    assign conf_old = r_conf[ch_idx];

    // Spike limit of the channel's sensor group.
    always_comb begin
        case (ch_idx) inside
            [4'd0:LAST_ACCEL_CH]:          limit = i_cfg.spike_limit_accel;
            [LAST_ACCEL_CH+4'd1:LAST_GYRO_CH]: limit = i_cfg.spike_limit_gyro;
            BARO_CHANNEL:                  limit = i_cfg.spike_limit_baro;
            default:                       limit = i_cfg.spike_limit_mag;
        endcase
    end

    // Exact jump magnitude, one bit wider than the samples.
    assign diff     = {item.sample_value[31], item.sample_value}
                    - $signed({last_eff[31], last_eff});
    assign jump     = diff[32] ? 33'(-diff) : 33'(diff);
    assign is_spike = (jump > {2'b00, limit});

    // Penalty scaling, truncated.
    assign pen_prod = {16'd0, conf_old} * {16'd0, i_cfg.penalty_factor};
    assign conf_pen = pen_prod[31:16];

    // Recovery with saturation at 1.0.
    assign ch_sum  = {1'b0, conf_old} + {1'b0, i_cfg.recovery_rate};
    assign ch_rec  = (ch_sum > {1'b0, CONF_ONE}) ? CONF_ONE : ch_sum[15:0];
    assign gps_sum = {1'b0, r_gps_conf} + {1'b0, i_cfg.recovery_rate};
    assign gps_rec = (gps_sum > {1'b0, CONF_ONE}) ? CONF_ONE : gps_sum[15:0];

    // Select the new channel confidence and last value.
    always_comb begin
        n_last = last_eff;
        if (ch_stale) begin
            n_conf = CONF_ZERO;
        end else if (is_spike) begin
            n_conf = conf_pen;
        end else begin
            n_conf = ch_rec;
            n_last = item.sample_value;
        end
    end

    // Next result word.
    always_comb begin
        if (is_gps) begin
            n_out.source     = GPS_SOURCE;
            n_out.confidence = gps_stale ? CONF_ZERO : gps_rec;
            n_out.timed_out  = gps_stale;
            n_out.spike      = 1'b0;
        end else begin
            n_out.source     = item.channel;
            n_out.confidence = n_conf;
            n_out.timed_out  = ch_stale;
            n_out.spike      = !ch_stale && is_spike;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_advance) begin
            n_out_valid = produce;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state: result valid, seeded flags and confidences.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seeded    <= '0;
            r_gps_conf  <= CONF_ZERO;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_conf[i] <= CONF_ZERO;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_advance) begin
                if (is_gps) begin
                    r_gps_conf <= n_out.confidence;
                end else if (in_range) begin
                    r_seeded[ch_idx] <= 1'b1;
                    r_conf[ch_idx]   <= n_conf;
                end
            end
        end
    end

    // Payload registers: last values and the result word.
    always_ff @(posedge i_clk) begin
        if (o_advance && !is_gps && in_range) begin
            r_last[ch_idx] <= n_last;
        end
        if (o_advance && produce) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### rtl/sensor_confidence_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_confidence_tracker: per-channel sensor confidence scoring
// Scores ten sensor channels and one GPS source from timestamps, sample
// jumps and fix status, one result word per accepted GPS word or channel 0-9 sample.
// ---------------------------------------------------------------------------
//  Port      Dir  Handshake           Word
//  i_in      in   valid/ready         mode, channel, sample, times, gps fix
//  o_out     out  valid/ready         source, confidence, timed_out, spike
//  i_cfg_*   in   write enable only   register index and 32-bit data
//
//  An accepted word moves from the input register through the update stage
//  into the result register; while the result is not stalled, one word is
//  accepted every cycle, set by the single update stage between the input
//  register and the result register. A sample with channel above 9 gives no
//  result. Reset is synchronous and clears all confidences and seed flags at
//  once. A stalled result holds the stage; the input register still takes a
//  word whenever it is empty.
// ---------------------------------------------------------------------------
module sensor_confidence_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sct_in_if.sink                         i_in,
    sct_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sct_pkg::*;

    t_cfg   cfg;
    t_stage stage;
    logic   advance;

    // Configuration registers.
    sct_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register.
    sct_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // Update stage and result register.
    sct_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stage   (stage),
        .o_advance (advance),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    // Confidence never goes above 1.0.
    a_conf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.confidence <= CONF_ONE))
        else $error("confidence above 1.0");

    // A timed-out word always reports zero confidence.
    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.timed_out) |-> (o_out.data.confidence == CONF_ZERO))
        else $error("timed-out word with nonzero confidence");

    // A spike is never reported together with a timeout, nor for GPS.
    a_spike_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.spike) |->
            (!o_out.data.timed_out && o_out.data.source != GPS_SOURCE))
        else $error("spike flag on stale or GPS word");

    // The input register never advances while the result slot is blocked.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !advance)
        else $error("update stage advanced into a stalled result");
`endif

endmodule
